>>> src/assert_macros.svh
// Assertion helpers for the checker in dvr_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define DVR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define DVR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/dvr_pkg.sv
package dvr_pkg;

  // Fixed field widths
  localparam int NODE_W    = 4;
  localparam int NODE_CNT  = 16;
  localparam int COST_W    = 16;
  localparam int DIST_W    = 17;
  localparam int HOP_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Default node count
  localparam int DEF_NODES = 16;

  typedef logic signed [DIST_W-1:0] dvr_dist_t;
  typedef logic signed [HOP_W-1:0]  dvr_hop_t;

  localparam dvr_dist_t DIST_UNREACH = '1;
  localparam dvr_hop_t  HOP_NONE     = '1;

  // Operation codes
  localparam logic OP_ENTRY = 1'b0;
  localparam logic OP_DROP  = 1'b1;

  // Result kinds
  localparam logic KIND_ROUTE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MY_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 2'd1;

  localparam logic [NODE_W-1:0] MY_ID_RST    = 4'd0;
  localparam logic [COST_W-1:0] MAX_DIST_RST = 16'd16;

  // Control of the shared compare unit
  typedef struct packed {
    logic init;      // load the direct-link candidate
    logic cand_vld;  // a stored vector distance is presented
  } dvr_cmp_ctl_t;

endpackage

>>> src/dvr_vec_mem.sv
module dvr_vec_mem
  import dvr_pkg::*;
#(
  parameter int DEPTH = DEF_NODES * NODE_CNT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [NODE_W-1:0] wr_row,
  input  logic [NODE_W-1:0] wr_col,
  input  dvr_dist_t         wr_data,
  input  logic              clr_en,
  input  logic [NODE_W-1:0] clr_row,
  input  logic              rd_en,
  input  logic [NODE_W-1:0] rd_row,
  input  logic [NODE_W-1:0] rd_col,
  output dvr_dist_t         rd_data
);

  localparam int AW = $clog2(DEPTH);

  logic [DIST_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [DIST_W-1:0] rd_q_r;
  logic              rd_vld_r;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  assign wr_addr = AW'({wr_row, wr_col});
  assign rd_addr = AW'({rd_row, rd_col});

  // Store the distance
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track written entries; a dropped row reads as unreachable again
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (clr_en && (NODE_W'(i >> NODE_W) == clr_row)) begin
          vld_r[i] <= 1'b0;
        end
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? dvr_dist_t'(rd_q_r) : DIST_UNREACH;

endmodule

>>> src/dvr_best_unit.sv
module dvr_best_unit
  import dvr_pkg::*;
(
  input  logic         clk,
  input  dvr_cmp_ctl_t ctl,
  input  dvr_dist_t    init_dist,
  input  dvr_hop_t     init_hop,
  input  dvr_dist_t    cand_dist,
  input  dvr_hop_t     cand_hop,
  output dvr_dist_t    best_dist,
  output dvr_hop_t     best_hop
);

  dvr_dist_t best_r;
  dvr_hop_t  hop_r;
  logic      better;

  // Unreachable loses to any distance; ties keep the held candidate
  always_comb begin
    if (cand_dist[DIST_W-1]) begin
      better = 1'b0;
    end else if (best_r[DIST_W-1]) begin
      better = 1'b1;
    end else begin
      better = cand_dist[DIST_W-2:0] < best_r[DIST_W-2:0];
    end
  end

  // Hold the running minimum
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      best_r <= init_dist;
      hop_r  <= init_hop;
    end else if (ctl.cand_vld && better) begin
      best_r <= cand_dist;
      hop_r  <= cand_hop;
    end
  end

  assign best_dist = best_r;
  assign best_hop  = hop_r;

endmodule

>>> src/distance_vector_route_update_unit.sv
// Vector entry without last: stored without a recompute; the input stays ready.
// Recompute (drop, or entry with last): the own id is skipped; every other destination
// goes through set-up, SPAN reads of the vector memory port, drain and decide,
// then the summary follows; a route change or the summary waits while the output stalls.
// The recompute is paced by the single read port of the vector memory and the shared compare.
// Reset (synchronous, active low) clears all tables and control.
module distance_vector_route_update_unit
  import dvr_pkg::*;
#(
  parameter int NODES = DEF_NODES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [NODE_W-1:0]    in_neighbour,
  input  logic [COST_W-1:0]    in_link_cost,
  input  logic [NODE_W-1:0]    in_dest,
  input  logic signed [DIST_W-1:0] in_dist_req,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [NODE_W-1:0]    out_dest_res,
  output logic signed [DIST_W-1:0] out_route_dist,
  output logic signed [HOP_W-1:0]  out_next_hop,
  output logic                 out_advertise,
  output logic                 out_final_res
);

  localparam int SPAN     = (NODES < NODE_CNT) ? NODES : NODE_CNT;
  localparam int VT_DEPTH = SPAN * NODE_CNT;
  localparam logic [NODE_W:0]   NODE_LIM = (NODE_W + 1)'(SPAN);
  localparam logic [NODE_W-1:0] IDX_LAST = NODE_W'(SPAN - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_WALK  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_SUM   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NODE_W-1:0] to_r, to_nxt;
  logic [NODE_W-1:0] via_r, via_nxt;
  logic              p_vld_r, p_vld_nxt;
  logic [NODE_W-1:0] p_via_r;

  logic [NODE_W-1:0] my_id_r;
  logic [COST_W-1:0] max_dist_r;

  logic              nbr_r [NODE_CNT];
  logic [COST_W-1:0] cost_r [NODE_CNT];
  dvr_dist_t         rdist_r [NODE_CNT];
  dvr_hop_t          rhop_r [NODE_CNT];
  logic              nbr_added_r;
  logic              changed_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [NODE_W-1:0] out_dest_r;
  dvr_dist_t         out_dist_r;
  dvr_hop_t          out_hop_r;
  logic              out_adv_r;
  logic              out_fin_r;

  logic              in_fire;
  logic              nb_ok, dst_ok, drop_ok;
  logic [DIST_W-1:0] sum;
  logic              d_ok;
  dvr_dist_t         vec_d;
  logic              mem_wr_en, mem_clr_en, mem_rd_en;
  dvr_dist_t         mem_rd_data;
  dvr_cmp_ctl_t      cmp_ctl;
  dvr_dist_t         init_dist, best_dist;
  dvr_hop_t          init_hop, best_hop;
  logic              chg, last_to, out_free;
  logic              load_chg, load_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_id_r    <= MY_ID_RST;
      max_dist_r <= MAX_DIST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MY_ID:    my_id_r    <= cfg_data[NODE_W-1:0];
        REG_MAX_DIST: max_dist_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry decode: distance through the sender, unreachable at or above max_distance
  assign nb_ok   = {1'b0, in_neighbour} < NODE_LIM;
  assign dst_ok  = {1'b0, in_dest} < NODE_LIM;
  assign drop_ok = nb_ok && nbr_r[in_neighbour];
  assign sum     = {1'b0, in_dist_req[DIST_W-2:0]} + {1'b0, in_link_cost};
  assign d_ok    = !in_dist_req[DIST_W-1] && (sum < {1'b0, max_dist_r});
  assign vec_d   = d_ok ? dvr_dist_t'(sum) : DIST_UNREACH;

  assign mem_wr_en  = in_fire && (in_op == OP_ENTRY) && nb_ok && dst_ok;
  assign mem_clr_en = in_fire && (in_op == OP_DROP) && drop_ok;

  dvr_vec_mem #(
    .DEPTH(VT_DEPTH)
  ) u_vec_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_row  (in_neighbour),
    .wr_col  (in_dest),
    .wr_data (vec_d),
    .clr_en  (mem_clr_en),
    .clr_row (in_neighbour),
    .rd_en   (mem_rd_en),
    .rd_row  (via_r),
    .rd_col  (to_r),
    .rd_data (mem_rd_data)
  );

  assign init_dist = nbr_r[to_r] ? dvr_dist_t'({1'b0, cost_r[to_r]}) : DIST_UNREACH;
  assign init_hop  = nbr_r[to_r] ? dvr_hop_t'({1'b0, to_r}) : HOP_NONE;

  dvr_best_unit u_best (
    .clk       (clk),
    .ctl       (cmp_ctl),
    .init_dist (init_dist),
    .init_hop  (init_hop),
    .cand_dist (mem_rd_data),
    .cand_hop  (dvr_hop_t'({1'b0, p_via_r})),
    .best_dist (best_dist),
    .best_hop  (best_hop)
  );

  assign chg      = (rdist_r[to_r] != best_dist);
  assign last_to  = (to_r == IDX_LAST);
  assign out_free = !out_valid_r || out_ready;

  // Recompute sequencer
  always_comb begin
    state_nxt        = state_r;
    to_nxt           = to_r;
    via_nxt          = via_r;
    p_vld_nxt        = 1'b0;
    mem_rd_en        = 1'b0;
    cmp_ctl.init     = 1'b0;
    cmp_ctl.cand_vld = p_vld_r;
    load_chg         = 1'b0;
    load_sum         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && ((in_op == OP_DROP) || in_last)) begin
          to_nxt    = '0;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (to_r == my_id_r) begin
          if (last_to) begin
            state_nxt = ST_SUM;
          end else begin
            to_nxt = to_r + 1'b1;
          end
        end else begin
          cmp_ctl.init = 1'b1;
          via_nxt      = '0;
          state_nxt    = ST_WALK;
        end
      end
      ST_WALK: begin
        mem_rd_en = 1'b1;
        p_vld_nxt = nbr_r[via_r];
        if (via_r == IDX_LAST) begin
          state_nxt = ST_DRAIN;
        end else begin
          via_nxt = via_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!chg || out_free) begin
          load_chg = chg;
          if (last_to) begin
            state_nxt = ST_SUM;
          end else begin
            to_nxt    = to_r + 1'b1;
            state_nxt = ST_START;
          end
        end
      end
      ST_SUM: begin
        if (out_free) begin
          load_sum  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      to_r    <= '0;
      via_r   <= '0;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      to_r    <= to_nxt;
      via_r   <= via_nxt;
      p_vld_r <= p_vld_nxt;
    end
  end

  // Hop of the vector entry in flight
  always_ff @(posedge clk) begin
    p_via_r <= via_r;
  end

  // Neighbour table, route table and change flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODE_CNT; i++) begin
        nbr_r[i]   <= 1'b0;
        cost_r[i]  <= '0;
        rdist_r[i] <= DIST_UNREACH;
        rhop_r[i]  <= HOP_NONE;
      end
      nbr_added_r <= 1'b0;
      changed_r   <= 1'b0;
    end else begin
      if (in_fire && (in_op == OP_ENTRY) && nb_ok) begin
        nbr_r[in_neighbour]  <= 1'b1;
        cost_r[in_neighbour] <= in_link_cost;
        if (!nbr_r[in_neighbour]) begin
          nbr_added_r <= 1'b1;
        end
      end
      if (mem_clr_en) begin
        nbr_r[in_neighbour]  <= 1'b0;
        cost_r[in_neighbour] <= '0;
      end
      if (load_chg) begin
        rdist_r[to_r] <= best_dist;
        rhop_r[to_r]  <= best_hop;
        changed_r     <= 1'b1;
      end
      if (load_sum) begin
        nbr_added_r <= 1'b0;
        changed_r   <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_chg || load_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_chg) begin
      out_kind_r <= KIND_ROUTE;
      out_dest_r <= to_r;
      out_dist_r <= best_dist;
      out_hop_r  <= best_hop;
      out_adv_r  <= 1'b0;
      out_fin_r  <= 1'b0;
    end else if (load_sum) begin
      out_kind_r <= KIND_SUMMARY;
      out_dest_r <= '0;
      out_dist_r <= '0;
      out_hop_r  <= '0;
      out_adv_r  <= changed_r || nbr_added_r;
      out_fin_r  <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_dest_res   = out_dest_r;
  assign out_route_dist = out_dist_r;
  assign out_next_hop   = out_hop_r;
  assign out_advertise  = out_adv_r;
  assign out_final_res  = out_fin_r;

endmodule

>>> src/dvr_checker.sv
`include "assert_macros.svh"

module dvr_checker
  import dvr_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_DAT_W-1:0] cfg_data,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_op,
  input logic [NODE_W-1:0]    in_neighbour,
  input logic [COST_W-1:0]    in_link_cost,
  input logic [NODE_W-1:0]    in_dest,
  input logic signed [DIST_W-1:0] in_dist_req,
  input logic                 in_last,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_kind,
  input logic [NODE_W-1:0]    out_dest_res,
  input logic signed [DIST_W-1:0] out_route_dist,
  input logic signed [HOP_W-1:0]  out_next_hop,
  input logic                 out_advertise,
  input logic                 out_final_res
);

  // A stalled result holds
  `DVR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_dest_res) && $stable(out_route_dist) && $stable(out_next_hop) && $stable(out_advertise) && $stable(out_final_res), "stalled result changed")

  // A drop always starts a recompute, so input is held off
  `DVR_ASSERT(a_drop_busy, clk, rst_n, in_valid && in_ready && (in_op == OP_DROP) |=> !in_ready, "input taken during recompute")

  // A plain vector entry leaves the input ready
  `DVR_ASSERT(a_entry_fast, clk, rst_n, in_valid && in_ready && (in_op == OP_ENTRY) && !in_last |=> in_ready, "vector entry held input off")

  // A route change is always followed by its summary, so the run is still open
  `DVR_ASSERT(a_route_in_run, clk, rst_n, out_valid && (out_kind == KIND_ROUTE) |-> !in_ready && !out_final_res, "route change outside a run")

endmodule

bind distance_vector_route_update_unit dvr_checker u_dvr_checker (.*);

>>> tb/route_table_checker.sv
`timescale 1ns / 100ps

// Watches the configuration, vector and route channels of the route update unit,
// keeps its own copy of the routing tables and compares every route transaction.
module route_table_checker
  import dvr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DAT_W-1:0]     cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_op,
  input  logic [NODE_W-1:0]        in_neighbour,
  input  logic [COST_W-1:0]        in_link_cost,
  input  logic [NODE_W-1:0]        in_dest,
  input  logic signed [DIST_W-1:0] in_dist_req,
  input  logic                     in_last,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_kind,
  input  logic [NODE_W-1:0]        out_dest_res,
  input  logic signed [DIST_W-1:0] out_route_dist,
  input  logic signed [HOP_W-1:0]  out_next_hop,
  input  logic                     out_advertise,
  input  logic                     out_final_res,
  input  logic                     run_done,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] dest;
    dvr_dist_t         dist_val;
    dvr_hop_t          hop;
    logic              adv;
    logic              fin;
  } route_update_t;

  route_update_t     route_updates_due[$];

  logic [NODE_W-1:0] own_id;
  logic [COST_W-1:0] max_dist;
  bit                is_nb [NODE_CNT];
  logic [COST_W-1:0] link_cost [NODE_CNT];
  dvr_dist_t         via_dist [NODE_CNT*NODE_CNT];
  dvr_dist_t         best_dist [NODE_CNT];
  dvr_hop_t          best_hop [NODE_CNT];
  bit                nb_added;
  int                mismatch_total;
  bit                leftover_checked;

  initial begin
    mismatch_total   = 0;
    leftover_checked = 1'b0;
    fail_count       = 0;
    pending          = 0;
  end

  // Unreachable loses against any distance
  function automatic bit shorter(dvr_dist_t a, dvr_dist_t b);
    if (a < 0) return 1'b0;
    if (b < 0) return 1'b1;
    return a < b;
  endfunction

  function automatic void reset_tables();
    own_id   = MY_ID_RST;
    max_dist = MAX_DIST_RST;
    nb_added = 1'b0;
    for (int n = 0; n < NODE_CNT; n++) begin
      is_nb[n]     = 1'b0;
      link_cost[n] = '0;
      best_dist[n] = DIST_UNREACH;
      best_hop[n]  = HOP_NONE;
    end
    for (int v = 0; v < NODE_CNT*NODE_CNT; v++) via_dist[v] = DIST_UNREACH;
  endfunction

  // Walk every destination but our own, queue each changed route, then the summary
  function automatic void recompute_routes();
    dvr_dist_t     best;
    dvr_hop_t      hop;
    bit            changed;
    route_update_t upd;
    changed = 1'b0;
    for (int t = 0; t < NODE_CNT; t++) begin
      if (t != own_id) begin
        best = DIST_UNREACH;
        hop  = HOP_NONE;
        if (is_nb[t]) begin
          best = {1'b0, link_cost[t]};
          hop  = t[HOP_W-1:0];
        end
        for (int v = 0; v < NODE_CNT; v++) begin
          if (is_nb[v] && shorter(via_dist[v*NODE_CNT+t], best)) begin
            best = via_dist[v*NODE_CNT+t];
            hop  = v[HOP_W-1:0];
          end
        end
        // a new next hop at the same distance is not a change
        if (best_dist[t] !== best) begin
          best_dist[t] = best;
          best_hop[t]  = hop;
          changed      = 1'b1;
          upd = '{KIND_ROUTE, t[NODE_W-1:0], best, hop, 1'b0, 1'b0};
          route_updates_due.push_back(upd);
        end
      end
    end
    upd = '{KIND_SUMMARY, '0, '0, '0, changed || nb_added, 1'b1};
    route_updates_due.push_back(upd);
    nb_added = 1'b0;
  endfunction

  // Apply one vector entry or neighbour drop to the tables
  function automatic void accept_item();
    int        sum;
    dvr_dist_t d;
    if (in_op == OP_ENTRY) begin
      if (!is_nb[in_neighbour]) nb_added = 1'b1;
      is_nb[in_neighbour]     = 1'b1;
      link_cost[in_neighbour] = in_link_cost;
      d = DIST_UNREACH;
      if (!in_dist_req[DIST_W-1]) begin
        sum = int'(in_dist_req[COST_W-1:0]) + int'(in_link_cost);
        if (sum < int'(max_dist)) d = sum[DIST_W-1:0];
      end
      via_dist[in_neighbour*NODE_CNT + in_dest] = d;
      if (in_last) recompute_routes();
    end else begin
      if (is_nb[in_neighbour]) begin
        is_nb[in_neighbour]     = 1'b0;
        link_cost[in_neighbour] = '0;
        for (int t = 0; t < NODE_CNT; t++) via_dist[in_neighbour*NODE_CNT + t] = DIST_UNREACH;
      end
      recompute_routes();
    end
  endfunction

  task automatic check_field(string what, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_total++;
    end
  endtask

  // Sample all three channels at the clock edge; predict before comparing
  always @(posedge clk) begin : watch
    route_update_t due;
    if (!rst_n) begin
      reset_tables();
      route_updates_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MY_ID) own_id = cfg_data[NODE_W-1:0];
        else if (cfg_index == REG_MAX_DIST) max_dist = cfg_data;
      end
      if (in_valid && in_ready) accept_item();
      if (out_valid && out_ready) begin
        if (route_updates_due.size() == 0) begin
          $display("%0t: route transaction with none expected: kind %0d dest %0d dist %0d hop %0d",
                   $time, out_kind, out_dest_res, out_route_dist, out_next_hop);
          mismatch_total++;
        end else begin
          due = route_updates_due.pop_front();
          check_field("kind", due.kind, out_kind);
          check_field("dest_res", due.dest, out_dest_res);
          check_field("route_dist", $signed(due.dist_val), out_route_dist);
          check_field("next_hop", $signed(due.hop), out_next_hop);
          check_field("advertise", due.adv, out_advertise);
          check_field("final_res", due.fin, out_final_res);
        end
      end
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (route_updates_due.size() != 0) begin
          $display("%0t: %0d route transactions expected but never seen, expected 0, actual %0d",
                   $time, route_updates_due.size(), route_updates_due.size());
          mismatch_total += route_updates_due.size();
        end
      end
    end
    pending    <= route_updates_due.size();
    fail_count <= mismatch_total;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import dvr_pkg::*;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         SETTLE_CYCLES = 300;
  localparam logic [7:0] STALL_PATTERN = 8'b1101_0011;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DAT_W-1:0]     cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_op;
  logic [NODE_W-1:0]        in_neighbour;
  logic [COST_W-1:0]        in_link_cost;
  logic [NODE_W-1:0]        in_dest;
  logic signed [DIST_W-1:0] in_dist_req;
  logic                     in_last;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_kind;
  logic [NODE_W-1:0]        out_dest_res;
  logic signed [DIST_W-1:0] out_route_dist;
  logic signed [HOP_W-1:0]  out_next_hop;
  logic                     out_advertise;
  logic                     out_final_res;
  logic                     run_done;
  int                       fail_count;
  int                       pending;
  int                       cycle_count;
  int                       burst_left;
  int                       entries_sent;
  int                       cur_max;
  logic [7:0]               stall_tick;
  logic [1:0]               stall_mode;

  distance_vector_route_update_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_neighbour   (in_neighbour),
    .in_link_cost   (in_link_cost),
    .in_dest        (in_dest),
    .in_dist_req    (in_dist_req),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_dest_res   (out_dest_res),
    .out_route_dist (out_route_dist),
    .out_next_hop   (out_next_hop),
    .out_advertise  (out_advertise),
    .out_final_res  (out_final_res)
  );

  route_table_checker route_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_neighbour   (in_neighbour),
    .in_link_cost   (in_link_cost),
    .in_dest        (in_dest),
    .in_dist_req    (in_dist_req),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_dest_res   (out_dest_res),
    .out_route_dist (out_route_dist),
    .out_next_hop   (out_next_hop),
    .out_advertise  (out_advertise),
    .out_final_res  (out_final_res),
    .run_done       (run_done),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver: pick a new random stall style whenever stall_tick[5:0] is zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ready <= STALL_PATTERN[stall_tick[2:0]];
      default: out_ready <= stall_tick[4];
    endcase
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one item and hold it until accepted, then maybe open a gap
  task automatic send_entry(logic op, logic [NODE_W-1:0] nb, logic [COST_W-1:0] cost,
                            logic [NODE_W-1:0] dst, int dist_val, logic lst);
    in_valid     <= 1'b1;
    in_op        <= op;
    in_neighbour <= nb;
    in_link_cost <= cost;
    in_dest      <= dst;
    in_dist_req  <= dist_val[DIST_W-1:0];
    in_last      <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    entries_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 40))
                                               : int'($urandom_range(0, 6));
    end
  endtask

  // Hold off until every expected route has come, then let the block settle
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; upper bits of the id word are don't-care
  task automatic write_config(logic [NODE_W-1:0] id, logic [COST_W-1:0] maxd);
    logic [CFG_DAT_W-NODE_W-1:0] pad;
    pad = (CFG_DAT_W-NODE_W)'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MY_ID;
    cfg_data  <= {pad, id};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_MAX_DIST;
    cfg_data  <= maxd;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_max = int'(maxd);
    @(posedge clk);
  endtask

  // Mostly distances near the current limit, with unreachable and huge ones mixed in
  function automatic int pick_distance();
    case ($urandom_range(0, 9))
      0:       return -1;
      1:       return -int'($urandom_range(1, 65536));
      2:       return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(0, (cur_max < 60000) ? cur_max + 2 : 65535));
    endcase
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 19))
      0:       return COST_W'($urandom_range(0, 65535));
      1:       return '0;
      2, 3:    return COST_W'($urandom_range(1, (cur_max > 1) ? cur_max : 1));
      default: return COST_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Mostly whole vectors from one neighbour, plus drops, broken vectors and noise
  task automatic run_random(int count);
    int                goal;
    int                len;
    int                shape;
    logic [NODE_W-1:0] nb;
    logic [COST_W-1:0] cost;
    goal = entries_sent + count;
    while (entries_sent < goal) begin
      shape = int'($urandom_range(0, 9));
      nb    = NODE_W'($urandom);
      cost  = pick_cost();
      len   = int'($urandom_range(1, 5));
      if (shape < 7) begin
        for (int k = 0; k < len; k++)
          send_entry(OP_ENTRY, nb, cost, NODE_W'($urandom), pick_distance(), k == len - 1);
      end else if (shape == 7) begin
        send_entry(OP_DROP, nb, pick_cost(), NODE_W'($urandom), pick_distance(),
                   1'($urandom));
      end else if (shape == 8) begin
        // cost wanders mid-vector and the vector never closes
        for (int k = 0; k < len; k++)
          send_entry(OP_ENTRY, nb, pick_cost(), NODE_W'($urandom), pick_distance(), 1'b0);
      end else begin
        send_entry(1'($urandom), nb, cost, NODE_W'($urandom), pick_distance(),
                   1'($urandom));
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_MY_ID;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_op        <= OP_ENTRY;
    in_neighbour <= '0;
    in_link_cost <= '0;
    in_dest      <= '0;
    in_dist_req  <= '0;
    in_last      <= 1'b0;
    out_ready    <= 1'b0;
    run_done     <= 1'b0;
    stall_tick   = '0;
    stall_mode   = 2'd0;
    cycle_count  = 0;
    burst_left   = 0;
    entries_sent = 0;
    cur_max      = MAX_DIST_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: own id 3, limit 16
    write_config(4'd3, 16'd16);
    send_entry(OP_ENTRY, 4'd1, 16'd1, 4'd2, 0, 1'b0);         // stored, no recompute
    send_entry(OP_ENTRY, 4'd1, 16'd1, 4'd5, 3, 1'b1);
    send_entry(OP_ENTRY, 4'd2, 16'hFFFF, 4'd2, 65535, 1'b1);  // sum far past the limit
    send_entry(OP_ENTRY, 4'd4, 16'd0, 4'd6, 2, 1'b1);         // zero link cost
    send_entry(OP_ENTRY, 4'd4, 16'd0, 4'd7, -1, 1'b1);        // unreachable entry
    send_entry(OP_ENTRY, 4'd4, 16'd2, 4'd7, -65536, 1'b1);    // most negative distance
    send_entry(OP_ENTRY, 4'd4, 16'd2, 4'd8, -2, 1'b1);
    send_entry(OP_ENTRY, 4'd5, 16'd3, 4'd3, 1, 1'b1);         // route to own id
    send_entry(OP_ENTRY, 4'd3, 16'd2, 4'd8, 4, 1'b1);         // own id as sender
    send_entry(OP_ENTRY, 4'd0, 16'd5, 4'd15, 10, 1'b0);
    send_entry(OP_ENTRY, 4'd15, 16'd1, 4'd0, 15, 1'b1);       // sum equals the limit
    send_entry(OP_ENTRY, 4'd15, 16'd1, 4'd0, 14, 1'b1);       // just under the limit
    send_entry(OP_ENTRY, 4'd15, 16'd1, 4'd15, 0, 1'b1);       // entry about the sender
    send_entry(OP_ENTRY, 4'd6, 16'd1, 4'd9, 2, 1'b1);
    send_entry(OP_ENTRY, 4'd7, 16'd1, 4'd9, 2, 1'b1);         // tie keeps the lower hop
    send_entry(OP_DROP, 4'd6, 16'd0, 4'd0, 0, 1'b0);          // hop moves, distance same
    send_entry(OP_DROP, 4'd9, 16'd0, 4'd0, 0, 1'b1);          // not a neighbour
    send_entry(OP_DROP, 4'd4, 16'hFFFF, 4'd15, -1, 1'b1);
    send_entry(OP_ENTRY, 4'd12, 16'h8000, 4'd10, 65535, 1'b0);
    send_entry(OP_ENTRY, 4'd10, 16'd7, 4'd11, 16'h5555, 1'b1);
    send_entry(OP_ENTRY, 4'd10, 16'd7, 4'd11, 5, 1'b1);
    send_entry(OP_DROP, 4'd15, 16'd0, 4'd0, 0, 1'b0);
    send_entry(OP_DROP, 4'd1, 16'd0, 4'd0, 0, 1'b0);
    wait_for_drain();

    // Random phases across the register extremes
    write_config(4'd0, 16'hFFFF);
    run_random(35);
    wait_for_drain();
    write_config(4'd15, 16'd1);
    run_random(15);
    wait_for_drain();
    write_config(4'd7, 16'd0);
    run_random(10);
    wait_for_drain();
    write_config(NODE_W'($urandom), COST_W'($urandom_range(8, 40)));
    run_random(35);
    wait_for_drain();
    run_random(12);
    wait_for_drain();

    run_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
